/* src/drq_pkg.sv */
`default_nettype none

package drq_pkg;

    localparam int unsigned ID_W   = 8;
    localparam int unsigned SEC_W  = 32;
    localparam int unsigned NSEC_W = 30;
    localparam int unsigned CNT_W  = 5;

    localparam logic [1:0] ACT_ENQ = 2'd0;
    localparam logic [1:0] ACT_DEQ = 2'd1;
    localparam logic [1:0] ACT_REM = 2'd2;
    localparam logic [1:0] ACT_CHK = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [ID_W-1:0]   thread_id;
        logic [SEC_W-1:0]  deadline_sec;
        logic [NSEC_W-1:0] deadline_nsec;
        logic              preempt_en;
        logic [SEC_W-1:0]  running_sec;
        logic [NSEC_W-1:0] running_nsec;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]  out_id;
        logic             decision;
        logic [CNT_W-1:0] entry_count;
        logic [1:0]       status;
    } t_out_item;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SEC_W-1:0]  sec;
        logic [NSEC_W-1:0] nsec;
    } t_entry;

    // deadline a at or before deadline b
    function automatic logic dl_le(
        input logic [SEC_W-1:0]  a_sec,
        input logic [NSEC_W-1:0] a_nsec,
        input logic [SEC_W-1:0]  b_sec,
        input logic [NSEC_W-1:0] b_nsec
    );
        logic res;
        if (a_sec != b_sec) begin
            res = (a_sec < b_sec);
        end else begin
            res = (a_nsec <= b_nsec);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* src/drq_ram.sv */
`default_nettype none

module drq_ram #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire drq_pkg::t_entry            i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output drq_pkg::t_entry                 o_rdata
);

    drq_pkg::t_entry r_mem [DEPTH];
    drq_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/drq_ctrl.sv */
`default_nettype none

module drq_ctrl #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire drq_pkg::t_in_item          i_item,
    output logic                            o_busy,
    input  wire logic                       i_res_take,
    output logic                            o_done,
    output drq_pkg::t_out_item              o_res,
    output logic                            o_mem_we,
    output logic [$clog2(DEPTH)-1:0]        o_mem_waddr,
    output drq_pkg::t_entry                 o_mem_wdata,
    output logic                            o_mem_re,
    output logic [$clog2(DEPTH)-1:0]        o_mem_raddr,
    input  wire drq_pkg::t_entry            i_mem_rdata
);

    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned OCC_W = $clog2(DEPTH + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ENQ_RD   = 4'd1;
    localparam logic [3:0] S_ENQ_CMP  = 4'd2;
    localparam logic [3:0] S_SCAN_RD  = 4'd3;
    localparam logic [3:0] S_SCAN_CMP = 4'd4;
    localparam logic [3:0] S_SHIFT_RD = 4'd5;
    localparam logic [3:0] S_SHIFT_WR = 4'd6;
    localparam logic [3:0] S_CHK_CMP  = 4'd7;
    localparam logic [3:0] S_FIN      = 4'd8;

    logic [3:0]                 r_state, n_state;
    logic [OCC_W-1:0]           r_occ, n_occ;
    logic [OCC_W-1:0]           r_idx, n_idx;
    drq_pkg::t_in_item          r_item, n_item;
    logic [drq_pkg::ID_W-1:0]   r_oid, n_oid;
    logic                       r_dec, n_dec;
    logic [1:0]                 r_st, n_st;

    logic [OCC_W-1:0]           idx_inc, idx_dec;
    drq_pkg::t_entry            e_new;
    logic                       occ_zero;

    assign idx_inc  = r_idx + 1'b1;
    assign idx_dec  = r_idx - 1'b1;
    assign occ_zero = (r_occ == '0);
    assign e_new    = '{id: r_item.thread_id, sec: r_item.deadline_sec,
                        nsec: r_item.deadline_nsec};

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_idx       = r_idx;
        n_item      = r_item;
        n_oid       = r_oid;
        n_dec       = r_dec;
        n_st        = r_st;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx[AW-1:0];
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_idx[AW-1:0];
        o_done      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item = i_item;
                    n_oid  = '0;
                    n_dec  = 1'b0;
                    n_st   = drq_pkg::ST_OK;
                    n_idx  = '0;
                    unique case (i_item.action)
                        drq_pkg::ACT_ENQ: begin
                            if (r_occ == OCC_W'(DEPTH)) begin
                                n_st    = drq_pkg::ST_FULL;
                                n_state = S_FIN;
                            end else begin
                                n_idx   = r_occ;
                                n_dec   = i_item.preempt_en &&
                                          !drq_pkg::dl_le(i_item.running_sec,
                                                          i_item.running_nsec,
                                                          i_item.deadline_sec,
                                                          i_item.deadline_nsec);
                                n_state = S_ENQ_RD;
                            end
                        end
                        drq_pkg::ACT_DEQ, drq_pkg::ACT_REM: begin
                            if (occ_zero) begin
                                n_st    = drq_pkg::ST_EMPTY;
                                n_state = S_FIN;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        drq_pkg::ACT_CHK: begin
                            if (occ_zero) begin
                                n_st    = drq_pkg::ST_EMPTY;
                                n_state = S_FIN;
                            end else begin
                                o_mem_re    = 1'b1;
                                o_mem_raddr = '0;
                                n_state     = S_CHK_CMP;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            // walk from the tail toward the head, moving later entries up by one
            S_ENQ_RD: begin
                if (r_idx == '0) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = e_new;
                    n_occ       = r_occ + 1'b1;
                    n_state     = S_FIN;
                end else begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = idx_dec[AW-1:0];
                    n_state     = S_ENQ_CMP;
                end
            end
            S_ENQ_CMP: begin
                o_mem_we = 1'b1;
                if (drq_pkg::dl_le(e_new.sec, e_new.nsec,
                                   i_mem_rdata.sec, i_mem_rdata.nsec)) begin
                    o_mem_wdata = i_mem_rdata;
                    n_idx       = idx_dec;
                    n_state     = S_ENQ_RD;
                end else begin
                    o_mem_wdata = e_new;
                    n_occ       = r_occ + 1'b1;
                    n_state     = S_FIN;
                end
            end
            S_SCAN_RD: begin
                if (r_idx == r_occ) begin
                    n_st    = drq_pkg::ST_NOT_FOUND;
                    n_state = S_FIN;
                end else begin
                    o_mem_re = 1'b1;
                    n_state  = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                n_idx = idx_inc;
                if (r_item.action == drq_pkg::ACT_DEQ ||
                    i_mem_rdata.id == r_item.thread_id) begin
                    if (r_item.action == drq_pkg::ACT_DEQ) begin
                        n_oid = i_mem_rdata.id;
                    end
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            // close the gap: move each later entry down by one
            S_SHIFT_RD: begin
                if (r_idx == r_occ) begin
                    n_occ   = r_occ - 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_mem_re = 1'b1;
                    n_state  = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = idx_dec[AW-1:0];
                o_mem_wdata = i_mem_rdata;
                n_idx       = idx_inc;
                n_state     = S_SHIFT_RD;
            end
            S_CHK_CMP: begin
                n_dec   = drq_pkg::dl_le(i_mem_rdata.sec, i_mem_rdata.nsec,
                                         r_item.deadline_sec, r_item.deadline_nsec);
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_res_take) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_item <= n_item;
        r_oid  <= n_oid;
        r_dec  <= n_dec;
        r_st   <= n_st;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_res  = '{out_id: r_oid, decision: r_dec,
                      entry_count: drq_pkg::CNT_W'(r_occ), status: r_st};

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_we && o_mem_re))
        else $error("memory read and write issued in the same cycle");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_FIN) |-> (r_idx <= r_occ))
        else $error("walk index beyond occupancy");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(DEPTH))
        else $error("occupancy beyond depth");

endmodule

`default_nettype wire

/* src/deadline_sorted_run_queue.sv */
// Each transaction runs to a registered result: an action that fails at once (full,
// empty) goes straight to the result; switch check reads the head entry; enqueue moves
// later entries up; dequeue and remove scan the queue and shift the entries after the hit.
// Only one transaction is in flight; the next is taken once the result is registered
// and the controller is back in idle; an output stall holds the controller in its final state.
// Reset clears the occupancy count; the slot memory is not cleared.
`default_nettype none

module deadline_sorted_run_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire drq_pkg::t_in_item   i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output drq_pkg::t_out_item       o_out_data
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic                   busy;
    logic                   done;
    logic                   res_take;
    drq_pkg::t_out_item     res;
    logic                   mem_we, mem_re;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    drq_pkg::t_entry        mem_wdata, mem_rdata;

    logic                   r_out_valid;
    drq_pkg::t_out_item     r_out;

    assign res_take = !r_out_valid || !i_out_stall;

    drq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && !busy),
        .i_item      (i_in_data),
        .o_busy      (busy),
        .i_res_take  (res_take),
        .o_done      (done),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    drq_ram #(.DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= res;
        end
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == drq_pkg::ST_EMPTY)
            |-> (o_out_data.entry_count == '0))
        else $error("empty status with nonzero count");

    a_dec_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.decision) |-> (o_out_data.status == drq_pkg::ST_OK))
        else $error("decision set on a failed transaction");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> res_take)
        else $error("result completed while output register full");

endmodule

`default_nettype wire
